/* src/bcmp_pkg.sv */
// package for the binomial coefficient engine mod prime
// holds the prime, command codes and table size default; no dependencies
package bcmp_pkg;

  localparam int unsigned TableSizeDefault = 4096;
  localparam logic [29:0] PRIME = 30'd1000000007;
  localparam logic [29:0] PRIME_EXP = 30'd1000000005;

  typedef enum logic [2:0] {
    CMD_COMB  = 3'd0,
    CMD_PERM  = 3'd1,
    CMD_STARS = 3'd2,
    CMD_GRID  = 3'd3,
    CMD_MSTART = 3'd4,
    CMD_MGROUP = 3'd5
  } cmd_t;

  // request to the shared modular multiplier
  typedef struct packed {
    logic        start;
    logic [29:0] a;
    logic [29:0] b;
  } mul_req_t;

endpackage

/* src/bcmp_ram.sv */
// generic single-port ram with registered read
// no dependencies
module bcmp_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/bcmp_mulmod.sv */
// shift-add modular multiplier, one bit of b per cycle
// uses bcmp_pkg for the prime and request struct
module bcmp_mulmod
  import bcmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mul_req_t    req,
  output logic        done,
  output logic [29:0] prod
);

  logic [29:0] acc_r, acc_nxt;
  logic [29:0] a_r, b_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [30:0] dbl, sum;
  logic [29:0] dred;

  // horner step: acc = 2*acc mod p, then add a when bit set
  always_comb begin
    dbl  = {acc_r, 1'b0};
    dred = (dbl >= {1'b0, PRIME}) ? 30'(dbl - {1'b0, PRIME}) : dbl[29:0];
    sum  = {1'b0, dred} + {1'b0, a_r};
    if (b_r[29]) begin
      acc_nxt = (sum >= {1'b0, PRIME}) ? 30'(sum - {1'b0, PRIME}) : sum[29:0];
    end else begin
      acc_nxt = dred;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= '0;
        acc_r  <= '0;
        a_r    <= (req.a >= PRIME) ? 30'(req.a - PRIME) : req.a;
        b_r    <= req.b;
      end else if (busy_r) begin
        acc_r  <= acc_nxt;
        b_r    <= {b_r[28:0], 1'b0};
        cnt_r  <= cnt_r + 5'd1;
        busy_r <= cnt_r != 5'd29;
        done_r <= cnt_r == 5'd29;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* src/binomial_coefficient_mod_prime.sv */
// Binomial coefficient engine modulo 1000000007. After reset the block
// fills a factorial table and an inverse-factorial table of TABLE_SIZE
// entries and takes the inverse of the last factorial by Fermat
// exponentiation, during which in_tready is low. Every modular product
// goes through one bit-serial shift-add multiplier. A zero, out-of-range
// or unused command needs no product, a multinomial start one table read,
// a multinomial group one read and one product, a permutation two reads
// and one product, and a combination, stars and bars or grid paths two
// products plus three table reads. One transaction is worked on at a time;
// its result sits in an output register so the next one may be accepted
// while it waits, though that next result is held until the register frees.
// depends on bcmp_pkg, bcmp_ram and bcmp_mulmod
module binomial_coefficient_mod_prime
  import bcmp_pkg::*;
#(
  parameter int TABLE_SIZE = TableSizeDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // command
  input  logic [31:0] in_tdata,   // first_arg [15:0], second_arg [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // value [29:0], out_of_range [30], zero fill
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam logic [20:0] TS = 21'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

  typedef enum logic [4:0] {
    S_FFILL, S_FWAIT, S_PSTART, S_PSQ, S_PSQW, S_PMUL, S_PMULW,
    S_IWRITE, S_IRD, S_IRDW, S_IMUL, S_IMULW,
    S_IDLE, S_RD1, S_RD1W, S_RD2, S_RD2W, S_MUL1, S_MUL1W, S_RD3, S_RD3W,
    S_MUL2, S_MUL2W, S_FIN, S_OUT
  } state_t;

  state_t      state_r;
  logic [AW-1:0] idx_r;
  logic [29:0] x_r, base_r, pacc_r, acc_r, res_r;
  logic [29:0] e_r;
  logic [4:0]  pcnt_r;
  logic [2:0]  cmd_r;
  logic [AW-1:0] i1_r, i2_r, i3_r;
  logic        oor_r;
  logic        outv_r;
  logic [29:0] ov_r;
  logic        oo_r;
  logic        f_we, i_we;
  logic [AW-1:0] f_addr, i_addr;
  logic [29:0] f_wd, i_wd, f_rd, i_rd;
  mul_req_t    mreq;
  logic        mstart_r, mstart_nxt;
  logic [29:0] ma_r, mb_r;
  logic        mdone;
  logic [29:0] mprod;

  logic [2:0]  cmd;
  logic [15:0] fa, sa;
  logic [16:0] n_w, r_w;
  logic        zero_w, oor_w;

  assign cmd = in_tuser;
  assign fa  = in_tdata[15:0];
  assign sa  = in_tdata[31:16];

  bcmp_ram #(.WIDTH(30), .DEPTH(TABLE_SIZE)) u_fact (
    .clk, .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));
  bcmp_ram #(.WIDTH(30), .DEPTH(TABLE_SIZE)) u_ifact (
    .clk, .we(i_we), .addr(i_addr), .wdata(i_wd), .rdata(i_rd));
  bcmp_mulmod u_mul (.clk, .rst_n, .req(mreq), .done(mdone), .prod(mprod));

  assign mreq = '{mstart_r, ma_r, mb_r};

  // decode n and r of the needed binomial
  always_comb begin
    n_w = {1'b0, fa};
    r_w = {1'b0, sa};
    case (cmd)
      CMD_STARS: begin
        n_w = 17'(fa) + 17'(sa) - 17'd1;
        r_w = 17'(sa) - 17'd1;
      end
      CMD_GRID: begin
        n_w = 17'(fa) + 17'(sa);
        r_w = {1'b0, fa};
      end
      CMD_MGROUP: n_w = {1'b0, sa};
      default: ;
    endcase
    zero_w = 1'b0;
    case (cmd)
      CMD_COMB, CMD_PERM: zero_w = sa > fa;
      CMD_STARS: zero_w = sa == 16'd0;
      default: ;
    endcase
    oor_w = {4'b0, n_w} >= TS;
  end

  // table ports
  always_comb begin
    f_we = 1'b0; i_we = 1'b0;
    f_addr = idx_r; i_addr = idx_r;
    f_wd = x_r; i_wd = x_r;
    case (state_r)
      S_FFILL:  f_we = 1'b1;
      S_IWRITE: i_we = 1'b1;
      S_RD1:    f_addr = i1_r;
      S_RD2:    i_addr = i2_r;
      S_RD3:    i_addr = i3_r;
      default: ;
    endcase
  end

  // states that hand a product to the multiplier
  always_comb begin
    case (state_r)
      S_FFILL:               mstart_nxt = idx_r != LAST;
      S_PSQ, S_RD2W, S_RD3W: mstart_nxt = 1'b1;
      S_PSQW:                mstart_nxt = mdone && e_r[29];
      S_IWRITE:              mstart_nxt = idx_r != '0;
      default:               mstart_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_FFILL;
      idx_r    <= '0;
      x_r      <= 30'd1;
      acc_r    <= '0;
      outv_r   <= 1'b0;
      mstart_r <= 1'b0;
    end else begin
      mstart_r <= mstart_nxt;
      outv_r   <= (state_r == S_OUT && (!outv_r || out_tready)) || (outv_r && !out_tready);
      case (state_r)
        // forward factorial fill: fact[idx] = x, then x *= idx+1
        S_FFILL: begin
          if (idx_r == LAST) begin
            base_r <= x_r;
            state_r <= S_PSTART;
          end else begin
            ma_r <= x_r; mb_r <= 30'(idx_r) + 30'd1;
            state_r <= S_FWAIT;
          end
        end
        S_FWAIT: if (mdone) begin
          x_r <= mprod; idx_r <= idx_r + 1'b1; state_r <= S_FFILL;
        end
        // fermat inverse of the last factorial, msb first
        S_PSTART: begin
          pacc_r <= 30'd1; e_r <= PRIME_EXP; i1_r <= '0; state_r <= S_PSQ;
          pcnt_r <= '0;
        end
        S_PSQ: begin
          ma_r <= pacc_r; mb_r <= pacc_r; state_r <= S_PSQW;
        end
        S_PSQW: if (mdone) begin
          pacc_r <= mprod;
          if (e_r[29]) begin
            ma_r <= mprod; mb_r <= base_r; state_r <= S_PMULW;
          end else state_r <= S_PMUL;
        end
        S_PMULW: if (mdone) begin
          pacc_r <= mprod; state_r <= S_PMUL;
        end
        S_PMUL: begin
          e_r <= {e_r[28:0], 1'b0};
          pcnt_r <= pcnt_r + 5'd1;
          if (pcnt_r == 5'd29) begin
            x_r <= pacc_r; idx_r <= LAST; state_r <= S_IWRITE;
          end else state_r <= S_PSQ;
        end
        // backward inverse fill: ifact[idx-1] = ifact[idx] * idx
        S_IWRITE: begin
          if (idx_r == '0) state_r <= S_IDLE;
          else begin
            ma_r <= x_r; mb_r <= 30'(idx_r); state_r <= S_IMULW;
          end
        end
        S_IMULW: if (mdone) begin
          x_r <= mprod; idx_r <= idx_r - 1'b1; state_r <= S_IWRITE;
        end
        S_IDLE: if (in_tvalid && in_tready) begin
          cmd_r <= cmd;
          i1_r <= AW'(n_w); i2_r <= AW'(r_w);
          i3_r <= (cmd == CMD_MGROUP) ? AW'(n_w) : AW'(n_w - r_w);
          if (cmd > CMD_MGROUP || zero_w) begin
            res_r <= '0; oor_r <= 1'b0; state_r <= S_OUT;
          end else if (oor_w) begin
            res_r <= '0; oor_r <= 1'b1; state_r <= S_OUT;
            if (cmd == CMD_MSTART) acc_r <= '0;
          end else begin
            oor_r <= 1'b0;
            state_r <= (cmd == CMD_MGROUP) ? S_RD3 : S_RD1;
          end
        end
        S_RD1: state_r <= S_RD1W;
        S_RD1W: begin
          x_r <= f_rd;
          if (cmd_r == CMD_MSTART) begin
            acc_r <= f_rd; res_r <= f_rd; state_r <= S_OUT;
          end else if (cmd_r == CMD_PERM) begin
            state_r <= S_RD3;
          end else state_r <= S_RD2;
        end
        S_RD2: state_r <= S_RD2W;
        S_RD2W: begin
          ma_r <= x_r; mb_r <= i_rd; state_r <= S_MUL1W;
        end
        S_MUL1W: if (mdone) begin
          x_r <= mprod; state_r <= S_RD3;
        end
        S_RD3: state_r <= S_RD3W;
        S_RD3W: begin
          ma_r <= (cmd_r == CMD_MGROUP) ? acc_r : x_r;
          mb_r <= i_rd;
          state_r <= S_MUL2W;
        end
        S_MUL2W: if (mdone) begin
          res_r <= mprod;
          if (cmd_r == CMD_MGROUP) acc_r <= mprod;
          state_r <= S_OUT;
        end
        // result register feeds the output channel
        S_OUT: if (!outv_r || out_tready) begin
          ov_r <= res_r; oo_r <= oor_r; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = outv_r;
  assign out_tdata  = {1'b0, oo_r, ov_r};

`ifndef NO_ASSERTIONS
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30] |-> out_tdata[29:0] == 30'd0) else $error("oor value");
  a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[29:0] < PRIME) else $error("value range");
  a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("second accept");
`endif

endmodule
